// ----- design/assert_macros.svh -----
// Assertion helpers for the scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is high.
`define CFS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs during reset.
`define CFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/cfs_pkg.sv -----
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types, event codes and lookup tables of the class file scanner.
// ----------------------------------------------------------------------------
package cfs_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef enum logic [2:0] {
      EV_BAD_MAGIC = 3'd0,
      EV_HEADER    = 3'd1,
      EV_POOL      = 3'd2,
      EV_FIELD     = 3'd3,
      EV_METHOD    = 3'd4,
      EV_CLASS_ATTR = 3'd5,
      EV_END       = 3'd6,
      EV_BAD_TAG   = 3'd7
   } event_type;

   localparam logic [3:0] HDR_MAGIC_DONE = 4'd0;
   localparam logic [3:0] HDR_POOL_CNT   = 4'd2;
   localparam logic [3:0] HDR_ACCESS     = 4'd3;
   localparam logic [3:0] HDR_IFACES     = 4'd6;
   localparam logic [3:0] HDR_FIELDS     = 4'd7;
   localparam logic [3:0] HDR_METHODS    = 4'd8;
   localparam logic [3:0] HDR_ATTRS      = 4'd9;

   localparam logic [7:0] TAG_UTF8   = 8'd1;
   localparam logic [7:0] TAG_LONG   = 8'd5;
   localparam logic [7:0] TAG_DOUBLE = 8'd6;

   // One queued result; dbl adds an end event right after it.
   typedef struct packed {
      event_type   ev;
      logic [3:0]  item;
      logic [31:0] off;
      logic [15:0] idx;
      logic [7:0]  tag;
      logic [31:0] val;
      logic        dbl;
   } ev_rec_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] pos);
      logic [7:0] r;
      case (pos)
         2'd0:    r = 8'hCA;
         2'd1:    r = 8'hFE;
         2'd2:    r = 8'hBA;
         default: r = 8'hBE;
      endcase
      return r;
   endfunction

   // Entry size in bytes including the tag, zero for tags with no size.
   function automatic logic [3:0] pool_size(input logic [7:0] t);
      logic [3:0] r;
      case (t)
         8'd3, 8'd4:                              r = 4'd5;
         8'd5, 8'd6:                              r = 4'd9;
         8'd7, 8'd8, 8'd16, 8'd19, 8'd20:         r = 4'd3;
         8'd9, 8'd10, 8'd11, 8'd12, 8'd17, 8'd18: r = 4'd5;
         8'd15:                                   r = 4'd4;
         default:                                 r = 4'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- design/class_file_structure_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// class_file_structure_scanner_unit
// Byte-serial Java class file structure scanner with queue-style ports.
// ----------------------------------------------------------------------------
//   channel  | ports                         | transfer when
//   ---------+-------------------------------+------------------------
//   request  | req_data_byte, req_first      | req_push && !req_full
//   response | rsp_event_res .. rsp_last     | rsp_pop && !rsp_empty
//
// One byte is taken per cycle while req_full is low; the walker updates its
// counters in that same cycle. Results pass through the queue and the output
// register. A byte that ends a zero-length attribute table yields two results,
// the second taken one pop later. The four-entry queue absorbs output stalls;
// req_full rises only when it is full. Synchronous reset clears control state
// and leaves the walker halted until a byte marked first arrives.
// ----------------------------------------------------------------------------
module class_file_structure_scanner_unit
   import cfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_event_res,
   output logic [3:0]  rsp_header_item,
   output logic [31:0] rsp_offset,
   output logic [15:0] rsp_index,
   output logic [7:0]  rsp_tag,
   output logic [31:0] rsp_value,
   output logic        rsp_last
);

   logic       take, f_push, q_pop, q_has;
   ev_rec_type f_rec, q_head;

   // Accept a byte whenever the queue has room for what it may produce.
   assign take = req_push && !req_full;

   cfs_front u_front (
      .clock, .reset, .take,
      .data_byte(req_data_byte), .first(req_first),
      .push(f_push), .rec(f_rec)
   );

   // Hold walker results until the output stage drains them.
   cfs_queue u_queue (
      .clock, .reset, .push(f_push), .push_rec(f_rec),
      .pop(q_pop), .head(q_head), .has_data(q_has), .full(req_full)
   );

   cfs_back u_back (
      .clock, .reset, .head(q_head), .has_data(q_has), .q_pop,
      .pop(rsp_pop), .empty(rsp_empty),
      .event_res(rsp_event_res), .header_item(rsp_header_item),
      .offset(rsp_offset), .index(rsp_index), .tag(rsp_tag),
      .value(rsp_value), .last(rsp_last)
   );

endmodule

// ----- design/cfs_front.sv -----
// ----------------------------------------------------------------------------
// cfs_front
// Byte walker: tracks the class file layout and classifies each byte.
// ----------------------------------------------------------------------------
module cfs_front
   import cfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [7:0]  data_byte,
   input  logic        first,
   output logic        push,
   output ev_rec_type  rec
);

   typedef enum logic [3:0] {
      PH_MAGIC, PH_HDR, PH_POOL_TAG, PH_UTF8_LEN, PH_POOL_SKIP,
      PH_IFACE_SKIP, PH_MEMBER, PH_ATTR_HEAD, PH_ATTR_SKIP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic [31:0] asm_ff, asm_in;
   logic [31:0] off_ff, off_in;
   logic [15:0] idx_ff, idx_in;
   logic [15:0] tot_ff, tot_in;
   logic [15:0] attrs_ff, attrs_in;
   logic [31:0] skip_ff, skip_in;
   logic [7:0]  tag_ff, tag_in;
   logic        halt_ff, halt_in;

   always_comb begin
      phase_type   ph;
      logic [2:0]  p;
      logic [31:0] a, o, sk;
      logic [15:0] ix, tt, ar, v;
      logic [7:0]  tg;
      logic [16:0] nxt;
      logic [3:0]  sz;
      logic        go, pe_done, mb_done, at_done;

      ph = phase_ff; p = pos_ff; a = asm_ff; o = off_ff; ix = idx_ff;
      tt = tot_ff; ar = attrs_ff; sk = skip_ff; tg = tag_ff;
      halt_in = halt_ff;
      nxt = '0;
      if (first) begin
         ph = PH_MAGIC; p = '0; a = '0; o = '0; ix = '0;
         tt = '0; ar = '0; sk = '0; tg = '0;
         halt_in = 1'b0;
      end
      go = take && (first || !halt_ff);
      push = 1'b0;
      rec = '{ev: EV_BAD_MAGIC, item: 4'd0, off: o, idx: 16'd0, tag: 8'd0,
              val: 32'd0, dbl: 1'b0};
      phase_in = ph; pos_in = p; asm_in = a; idx_in = ix; tot_in = tt;
      attrs_in = ar; skip_in = sk; tag_in = tg;
      pe_done = 1'b0; mb_done = 1'b0; at_done = 1'b0;
      v = {a[7:0], data_byte};
      sz = pool_size(data_byte);

      if (go) begin
         unique case (ph)
            PH_MAGIC: begin
               if (data_byte != magic_byte(p[1:0])) begin
                  push = 1'b1;
                  rec.val = {24'd0, data_byte};
                  halt_in = 1'b1;
               end else if (p >= 3'd3) begin
                  phase_in = PH_HDR; idx_in = {12'd0, HDR_MAGIC_DONE}; pos_in = '0;
               end else begin
                  pos_in = p + 3'd1;
               end
            end
            PH_HDR: begin
               if (p == 3'd0) begin
                  asm_in = {24'd0, data_byte}; pos_in = 3'd1;
               end else begin
                  asm_in = {16'd0, v};
                  push = 1'b1;
                  rec.ev = EV_HEADER; rec.item = ix[3:0];
                  rec.off = o - 32'd1; rec.val = {16'd0, v};
                  pos_in = '0;
                  case (ix[3:0])
                     HDR_POOL_CNT: begin
                        tot_in = v;
                        if (v > 16'd1) begin
                           idx_in = 16'd1; phase_in = PH_POOL_TAG;
                        end else begin
                           idx_in = {12'd0, HDR_ACCESS};
                        end
                     end
                     HDR_IFACES: begin
                        skip_in = {15'd0, v, 1'b0};
                        if (v == 16'd0) idx_in = {12'd0, HDR_FIELDS};
                        else phase_in = PH_IFACE_SKIP;
                     end
                     HDR_FIELDS, HDR_METHODS: begin
                        tot_in = v;
                        tag_in = (ix[3:0] == HDR_FIELDS) ? {5'd0, EV_FIELD}
                                                         : {5'd0, EV_METHOD};
                        if (v == 16'd0) begin
                           idx_in = (ix[3:0] == HDR_FIELDS) ? {12'd0, HDR_METHODS}
                                                            : {12'd0, HDR_ATTRS};
                        end else begin
                           idx_in = '0; phase_in = PH_MEMBER;
                        end
                     end
                     HDR_ATTRS: begin
                        if (v == 16'd0) begin
                           rec.dbl = 1'b1; halt_in = 1'b1;
                        end else begin
                           tot_in = v; tag_in = {5'd0, EV_CLASS_ATTR};
                           idx_in = '0; phase_in = PH_ATTR_HEAD;
                        end
                     end
                     default: idx_in = ix + 16'd1;
                  endcase
               end
            end
            PH_POOL_TAG: begin
               tag_in = data_byte;
               push = 1'b1;
               rec.idx = ix; rec.tag = data_byte; rec.ev = EV_POOL;
               if (data_byte == TAG_UTF8) begin
                  pos_in = '0; phase_in = PH_UTF8_LEN;
               end else if (sz == 4'd0) begin
                  rec.ev = EV_BAD_TAG; halt_in = 1'b1;
               end else begin
                  skip_in = {28'd0, sz - 4'd1}; phase_in = PH_POOL_SKIP;
               end
            end
            PH_UTF8_LEN: begin
               if (p == 3'd0) begin
                  asm_in = {24'd0, data_byte}; pos_in = 3'd1;
               end else begin
                  asm_in = {16'd0, v}; skip_in = {16'd0, v};
                  if (v == 16'd0) pe_done = 1'b1;
                  else phase_in = PH_POOL_SKIP;
               end
            end
            PH_POOL_SKIP: begin
               skip_in = sk - 32'd1;
               if (skip_in == 32'd0) pe_done = 1'b1;
            end
            PH_IFACE_SKIP: begin
               skip_in = sk - 32'd1;
               if (skip_in == 32'd0) begin
                  phase_in = PH_HDR; idx_in = {12'd0, HDR_FIELDS}; pos_in = '0;
               end
            end
            PH_MEMBER: begin
               if (p == 3'd0) begin
                  push = 1'b1; rec.ev = event_type'(tg[2:0]); rec.idx = ix;
               end
               if (p == 3'd6) begin
                  asm_in = {24'd0, data_byte}; pos_in = p + 3'd1;
               end else if (p == 3'd7) begin
                  asm_in = {16'd0, v}; attrs_in = v; pos_in = '0;
                  if (v == 16'd0) mb_done = 1'b1;
                  else phase_in = PH_ATTR_HEAD;
               end else begin
                  pos_in = p + 3'd1;
               end
            end
            PH_ATTR_HEAD: begin
               if (p == 3'd0 && tg == {5'd0, EV_CLASS_ATTR}) begin
                  push = 1'b1; rec.ev = EV_CLASS_ATTR; rec.idx = ix;
               end
               if (p == 3'd2) asm_in = {24'd0, data_byte};
               else if (p > 3'd2) asm_in = {a[23:0], data_byte};
               if (p >= 3'd5) begin
                  skip_in = asm_in; pos_in = '0;
                  if (asm_in == 32'd0) at_done = 1'b1;
                  else phase_in = PH_ATTR_SKIP;
               end else begin
                  pos_in = p + 3'd1;
               end
            end
            PH_ATTR_SKIP: begin
               skip_in = sk - 32'd1;
               if (skip_in == 32'd0) at_done = 1'b1;
            end
            default: halt_in = 1'b1;
         endcase

         if (at_done) begin
            pos_in = '0;
            if (tg == {5'd0, EV_CLASS_ATTR}) begin
               nxt = {1'b0, ix} + 17'd1;
               if (nxt < {1'b0, tt}) begin
                  idx_in = nxt[15:0]; phase_in = PH_ATTR_HEAD;
               end else begin
                  push = 1'b1; rec.ev = EV_END;
                  rec.off = o + 32'd1; rec.val = o + 32'd1;
                  halt_in = 1'b1;
               end
            end else begin
               attrs_in = ar - 16'd1;
               if (attrs_in != 16'd0) phase_in = PH_ATTR_HEAD;
               else mb_done = 1'b1;
            end
         end
         if (mb_done) begin
            nxt = {1'b0, ix} + 17'd1;
            if (nxt < {1'b0, tt}) begin
               idx_in = nxt[15:0]; pos_in = '0; phase_in = PH_MEMBER;
            end else begin
               phase_in = PH_HDR; pos_in = '0;
               idx_in = (tg == {5'd0, EV_FIELD}) ? {12'd0, HDR_METHODS}
                                                 : {12'd0, HDR_ATTRS};
            end
         end
         if (pe_done) begin
            nxt = {1'b0, ix} + ((tg == TAG_LONG || tg == TAG_DOUBLE) ? 17'd2 : 17'd1);
            if (nxt < {1'b0, tt}) begin
               idx_in = nxt[15:0]; phase_in = PH_POOL_TAG;
            end else begin
               phase_in = PH_HDR; idx_in = {12'd0, HDR_ACCESS}; pos_in = '0;
            end
         end
      end
      off_in = go ? o + 32'd1 : off_ff;
      if (!go) begin
         phase_in = phase_ff; pos_in = pos_ff; asm_in = asm_ff; idx_in = idx_ff;
         tot_in = tot_ff; attrs_in = attrs_ff; skip_in = skip_ff; tag_in = tag_ff;
         halt_in = halt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC; pos_ff <= '0; asm_ff <= '0; off_ff <= '0;
         idx_ff <= '0; tot_ff <= '0; attrs_ff <= '0; skip_ff <= '0;
         tag_ff <= '0; halt_ff <= 1'b1;
      end else begin
         phase_ff <= phase_in; pos_ff <= pos_in; asm_ff <= asm_in; off_ff <= off_in;
         idx_ff <= idx_in; tot_ff <= tot_in; attrs_ff <= attrs_in; skip_ff <= skip_in;
         tag_ff <= tag_in; halt_ff <= halt_in;
      end
   end

endmodule

// ----- design/cfs_queue.sv -----
// ----------------------------------------------------------------------------
// cfs_queue
// Short result queue between the byte walker and the output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfs_queue
   import cfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ev_rec_type  push_rec,
   input  logic        pop,
   output ev_rec_type  head,
   output logic        has_data,
   output logic        full
);

   ev_rec_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ff, rd_ff;
   logic [QPTR_W:0]    cnt_ff;

   assign has_data = (cnt_ff != '0);
   assign full     = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign head     = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
      end
   end

   `CFS_ASSERT(q_no_overflow, clock, reset, !(push && full), "queue push while full")
   `CFS_ASSERT(q_no_underflow, clock, reset, !(pop && !has_data), "queue pop while empty")
   `CFS_ASSERT(q_count_up, clock, reset, (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1), "queue count did not advance")

endmodule

// ----- design/cfs_back.sv -----
// ----------------------------------------------------------------------------
// cfs_back
// Output stage: holds the current result and expands an attached end event.
// ----------------------------------------------------------------------------
module cfs_back
   import cfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ev_rec_type  head,
   input  logic        has_data,
   output logic        q_pop,
   input  logic        pop,
   output logic        empty,
   output logic [2:0]  event_res,
   output logic [3:0]  header_item,
   output logic [31:0] offset,
   output logic [15:0] index,
   output logic [7:0]  tag,
   output logic [31:0] value,
   output logic        last
);

   ev_rec_type rec_ff;
   logic       valid_ff, second_ff;
   logic       advance, need_second;
   logic [31:0] end_off;

   assign need_second = valid_ff && !second_ff && rec_ff.dbl;
   assign advance     = !valid_ff || pop;
   assign q_pop       = advance && !need_second && has_data;
   assign empty       = !valid_ff;
   assign end_off     = rec_ff.off + 32'd2;

   always_comb begin
      if (second_ff) begin
         event_res = EV_END; header_item = '0; offset = end_off;
         index = '0; tag = '0; value = end_off; last = 1'b1;
      end else begin
         event_res = rec_ff.ev; header_item = rec_ff.item; offset = rec_ff.off;
         index = rec_ff.idx; tag = rec_ff.tag; value = rec_ff.val; last = !rec_ff.dbl;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) rec_ff <= head;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0; second_ff <= 1'b0;
      end else if (advance) begin
         if (need_second) begin
            second_ff <= 1'b1;
         end else begin
            valid_ff  <= has_data;
            second_ff <= 1'b0;
         end
      end
   end

endmodule
